// ===== src/lkvc_pkg.sv =====
// shared constants and types for the lru key/value cache
package lkvc_pkg;

   localparam int DefaultMaxEntries = 16;
   localparam int DataWidth = 32;
   localparam int CapWidth = 5;

   localparam logic [CapWidth-1:0] CapReset = CapWidth'(16);
   localparam logic [DataWidth-1:0] MissValue = '1;

   localparam logic CmdGet = 1'b0;
   localparam logic CmdPut = 1'b1;

   typedef struct packed {
      logic hit;
      logic insert;
      logic evict;
   } lkvc_action_type;

endpackage

// ===== src/lru_key_value_cache_top.sv =====
// lru key/value cache top level: input register, lookup, slots, result register
//
//   channel  ports                                    handshake
//   req      req_command req_lookup_key req_write_value  start / busy
//   rsp      rsp_hit rsp_read_value rsp_evicted          rsp_strobe, one cycle
//            rsp_evicted_key
//   csr      csr_wdata                                 csr_we
//
// one word accepted every cycle; busy is never raised
// the result strobe follows the accepting edge through the input register,
// the combinational lookup with its slot update and the result register
// reset clears valid marks, ranks, fill count and sets capacity to 16
// the receiver cannot stall: each result is shown for exactly one cycle
module lru_key_value_cache_top
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = DefaultMaxEntries
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic signed [DataWidth-1:0] req_lookup_key,
   input  logic signed [DataWidth-1:0] req_write_value,
   output logic                        rsp_strobe,
   output logic                        rsp_hit,
   output logic signed [DataWidth-1:0] rsp_read_value,
   output logic                        rsp_evicted,
   output logic signed [DataWidth-1:0] rsp_evicted_key,
   input  logic                        csr_we,
   input  logic [CapWidth-1:0]         csr_wdata
);

   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam int AgeW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CmpW = (CntW > CapWidth) ? CntW : CapWidth;

   logic                   stage_valid_ff;
   logic                   stage_command_ff;
   logic [DataWidth-1:0]   stage_key_ff;
   logic [DataWidth-1:0]   stage_value_ff;
   logic [CapWidth-1:0]    capacity_ff;

   logic                   strobe_ff;
   logic                   hit_ff;
   logic [DataWidth-1:0]   read_value_ff;
   logic                   evicted_ff;
   logic [DataWidth-1:0]   evicted_key_ff;

   logic                   accept;
   logic [CmpW-1:0]        cap_raw;
   logic [CmpW-1:0]        cap_eff;
   logic                   room;

   logic [MAX_ENTRIES-1:0] slot_valid;
   logic [DataWidth-1:0]   slot_key [MAX_ENTRIES];
   logic [DataWidth-1:0]   slot_value [MAX_ENTRIES];
   logic [AgeW-1:0]        slot_age [MAX_ENTRIES];
   logic [CntW-1:0]        occupied_count;
   logic [MAX_ENTRIES-1:0] match_oh;
   logic [MAX_ENTRIES-1:0] sel_oh;
   logic [AgeW-1:0]        ref_age;
   lkvc_action_type        action;
   logic [DataWidth-1:0]   read_value;
   logic [DataWidth-1:0]   evicted_key;

   assign busy = 1'b0;
   assign accept = start && !busy;

   // capacity clamped to 1..MAX_ENTRIES
   assign cap_raw = CmpW'(capacity_ff);
   always_comb begin
      if (cap_raw == '0) begin
         cap_eff = CmpW'(1);
      end else if (cap_raw > CmpW'(MAX_ENTRIES)) begin
         cap_eff = CmpW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_raw;
      end
   end
   assign room = CmpW'(occupied_count) < cap_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapReset;
         stage_valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         stage_valid_ff <= accept;
         strobe_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_command_ff <= req_command;
         stage_key_ff <= req_lookup_key;
         stage_value_ff <= req_write_value;
      end
      if (stage_valid_ff) begin
         hit_ff <= action.hit;
         read_value_ff <= read_value;
         evicted_ff <= action.evict;
         evicted_key_ff <= evicted_key;
      end
   end

   lkvc_lookup #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_lookup (
      .op_command    (stage_command_ff),
      .op_key        (stage_key_ff),
      .room          (room),
      .slot_valid    (slot_valid),
      .slot_key      (slot_key),
      .slot_value    (slot_value),
      .slot_age      (slot_age),
      .occupied_count(occupied_count),
      .match_oh      (match_oh),
      .sel_oh        (sel_oh),
      .ref_age       (ref_age),
      .action        (action),
      .read_value    (read_value),
      .evicted_key   (evicted_key)
   );

   lkvc_slots #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_slots (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (stage_valid_ff),
      .op_command    (stage_command_ff),
      .op_key        (stage_key_ff),
      .op_value      (stage_value_ff),
      .action        (action),
      .sel_oh        (sel_oh),
      .ref_age       (ref_age),
      .slot_valid    (slot_valid),
      .slot_key      (slot_key),
      .slot_value    (slot_value),
      .slot_age      (slot_age),
      .occupied_count(occupied_count)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_hit = hit_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_evicted = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

`ifndef SYNTHESIS
   a_word_gets_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted word produced no result");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid) == int'(occupied_count))
      else $error("fill count disagrees with valid marks");

   a_key_unique: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> $onehot0(match_oh))
      else $error("key stored in more than one slot");

   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");
`endif

endmodule

// ===== src/lkvc_lookup.sv =====
// key match, victim and free slot search, result selection
module lkvc_lookup
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = DefaultMaxEntries,
   localparam int CntW = $clog2(MAX_ENTRIES + 1),
   localparam int AgeW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                 op_command,
   input  logic [DataWidth-1:0] op_key,
   input  logic                 room,
   input  logic [MAX_ENTRIES-1:0] slot_valid,
   input  logic [DataWidth-1:0] slot_key [MAX_ENTRIES],
   input  logic [DataWidth-1:0] slot_value [MAX_ENTRIES],
   input  logic [AgeW-1:0]      slot_age [MAX_ENTRIES],
   input  logic [CntW-1:0]      occupied_count,
   output logic [MAX_ENTRIES-1:0] match_oh,
   output logic [MAX_ENTRIES-1:0] sel_oh,
   output logic [AgeW-1:0]      ref_age,
   output lkvc_action_type      action,
   output logic [DataWidth-1:0] read_value,
   output logic [DataWidth-1:0] evicted_key
);

   logic [MAX_ENTRIES-1:0] victim_oh;
   logic [MAX_ENTRIES-1:0] free_oh;
   logic [MAX_ENTRIES-1:0] invalid;
   logic [AgeW-1:0]        lru_age;
   logic [AgeW-1:0]        hit_age;
   logic [DataWidth-1:0]   hit_value;
   logic [DataWidth-1:0]   victim_key;
   logic                   hit;

   assign lru_age = AgeW'(occupied_count - CntW'(1));
   assign invalid = ~slot_valid;
   assign free_oh = invalid & (~invalid + MAX_ENTRIES'(1));

   always_comb begin
      match_oh = '0;
      victim_oh = '0;
      hit_age = '0;
      hit_value = '0;
      victim_key = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_oh[i] = slot_valid[i] && (slot_key[i] == op_key);
         victim_oh[i] = slot_valid[i] && (slot_age[i] == lru_age);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_age = hit_age | ({AgeW{match_oh[i]}} & slot_age[i]);
         hit_value = hit_value | ({DataWidth{match_oh[i]}} & slot_value[i]);
         victim_key = victim_key | ({DataWidth{victim_oh[i]}} & slot_key[i]);
      end
   end

   assign hit = |match_oh;

   always_comb begin
      action.hit = hit;
      action.insert = (op_command == CmdPut) && !hit && room;
      action.evict = (op_command == CmdPut) && !hit && !room;
   end

   always_comb begin
      if (action.hit) begin
         sel_oh = match_oh;
         ref_age = hit_age;
      end else if (action.insert) begin
         sel_oh = free_oh;
         ref_age = AgeW'(occupied_count);
      end else begin
         sel_oh = victim_oh;
         ref_age = lru_age;
      end
   end

   always_comb begin
      if (op_command == CmdGet) begin
         read_value = hit ? hit_value : MissValue;
      end else begin
         read_value = '0;
      end
      evicted_key = action.evict ? victim_key : '0;
   end

endmodule

// ===== src/lkvc_slots.sv =====
// slot storage: valid marks, keys, values, recency ranks and fill count
module lkvc_slots
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = DefaultMaxEntries,
   localparam int CntW = $clog2(MAX_ENTRIES + 1),
   localparam int AgeW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  logic                   op_command,
   input  logic [DataWidth-1:0]   op_key,
   input  logic [DataWidth-1:0]   op_value,
   input  lkvc_action_type        action,
   input  logic [MAX_ENTRIES-1:0] sel_oh,
   input  logic [AgeW-1:0]        ref_age,
   output logic [MAX_ENTRIES-1:0] slot_valid,
   output logic [DataWidth-1:0]   slot_key [MAX_ENTRIES],
   output logic [DataWidth-1:0]   slot_value [MAX_ENTRIES],
   output logic [AgeW-1:0]        slot_age [MAX_ENTRIES],
   output logic [CntW-1:0]        occupied_count
);

   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [AgeW-1:0]        age_ff [MAX_ENTRIES];
   logic [AgeW-1:0]        age_in [MAX_ENTRIES];
   logic [DataWidth-1:0]   key_ff [MAX_ENTRIES];
   logic [DataWidth-1:0]   value_ff [MAX_ENTRIES];
   logic [CntW-1:0]        count_ff, count_in;
   logic                   upd_en;
   logic                   key_wr;
   logic                   value_wr;

   assign upd_en = op_valid && (action.hit || action.insert || action.evict);
   assign key_wr = op_valid && (action.insert || action.evict);
   assign value_wr = op_valid && (op_command == CmdPut);

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (upd_en) begin
            if (sel_oh[i]) begin
               valid_in[i] = 1'b1;
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < ref_age)) begin
               age_in[i] = age_ff[i] + AgeW'(1);
            end
         end
      end
      if (op_valid && action.insert) begin
         count_in = count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (key_wr && sel_oh[i]) begin
            key_ff[i] <= op_key;
         end
         if (value_wr && sel_oh[i]) begin
            value_ff[i] <= op_value;
         end
      end
   end

   assign slot_valid = valid_ff;
   assign slot_key = key_ff;
   assign slot_value = value_ff;
   assign slot_age = age_ff;
   assign occupied_count = count_ff;

endmodule
